### rtl/core/tdpt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tdpt_pkg
// Shared types and constants for the trial-division prime tester.
// ----------------------------------------------------------------------------
package tdpt_pkg;

    localparam int VALUE_WIDTH_DEFAULT = 32;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_DIVIDE,
        ST_TEST,
        ST_FINISH
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;        // take a new candidate, restart divisor at two
        logic div_start;   // begin a remainder computation
        logic div_step;    // one bit of the serial remainder
        logic next_div;    // advance divisor and its square
        logic out_load;    // capture the result into the output register
        logic prime;       // verdict written with out_load
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic le_one;      // candidate is negative, zero or one
        logic sq_over;     // divisor squared exceeds the candidate
        logic div_last;    // the current step is the last remainder bit
        logic rem_zero;    // remainder of the last computation is zero
    } dp_status_t;

endpackage

### rtl/core/tdpt_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tdpt_ctrl
// Controller: sequences bound check, serial remainder and result handoff.
// ----------------------------------------------------------------------------
module tdpt_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    input  tdpt_pkg::dp_status_t status,
    output tdpt_pkg::dp_cmd_t    cmd
);

    tdpt_pkg::state_t state_reg, state_next;
    logic             prime_reg, prime_next;
    logic             out_valid_reg, out_valid_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= tdpt_pkg::ST_IDLE;
            prime_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            prime_reg     <= prime_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb begin
        state_next     = state_reg;
        prime_next     = prime_reg;
        out_valid_next = out_valid_reg;
        cmd            = '0;
        cmd.prime      = prime_reg;
        s_tready       = 1'b0;

        // The output register drains independently of the search.
        if (out_valid_reg && m_tready) begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            tdpt_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = tdpt_pkg::ST_CHECK;
                end
            end
            tdpt_pkg::ST_CHECK: begin
                if (status.le_one) begin
                    prime_next = 1'b0;
                    state_next = tdpt_pkg::ST_FINISH;
                end else if (status.sq_over) begin
                    prime_next = 1'b1;
                    state_next = tdpt_pkg::ST_FINISH;
                end else begin
                    cmd.div_start = 1'b1;
                    state_next    = tdpt_pkg::ST_DIVIDE;
                end
            end
            tdpt_pkg::ST_DIVIDE: begin
                cmd.div_step = 1'b1;
                if (status.div_last) begin
                    state_next = tdpt_pkg::ST_TEST;
                end
            end
            tdpt_pkg::ST_TEST: begin
                if (status.rem_zero) begin
                    prime_next = 1'b0;
                    state_next = tdpt_pkg::ST_FINISH;
                end else begin
                    cmd.next_div = 1'b1;
                    state_next   = tdpt_pkg::ST_CHECK;
                end
            end
            tdpt_pkg::ST_FINISH: begin
                if (!out_valid_reg || m_tready) begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = tdpt_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = tdpt_pkg::ST_IDLE;
            end
        endcase
    end

    assign m_tvalid = out_valid_reg;

endmodule

### rtl/core/tdpt_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tdpt_datapath
// Datapath: candidate, divisor with running square, bit-serial remainder
// and the output register.
// ----------------------------------------------------------------------------
module tdpt_datapath #(
    parameter int VALUE_WIDTH = tdpt_pkg::VALUE_WIDTH_DEFAULT
) (
    input  logic                   aclk,
    input  logic [VALUE_WIDTH-1:0] in_value,
    input  tdpt_pkg::dp_cmd_t      cmd,
    output tdpt_pkg::dp_status_t   status,
    output logic [VALUE_WIDTH-1:0] out_value,
    output logic                   out_prime
);

    localparam int DIV_W = VALUE_WIDTH / 2 + 1;
    localparam int SQ_W  = 2 * DIV_W;
    localparam int CNT_W = $clog2(VALUE_WIDTH);

    logic [VALUE_WIDTH-1:0] value_reg;
    logic [DIV_W-1:0]       div_reg, div_next;
    logic [SQ_W-1:0]        sq_reg, sq_next;
    logic [VALUE_WIDTH-1:0] shift_reg, shift_next;
    logic [DIV_W-1:0]       rem_reg, rem_next;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;
    logic [VALUE_WIDTH-1:0] out_value_reg;
    logic                   out_prime_reg;
    logic [DIV_W:0]         trial;
    logic [DIV_W:0]         diff;

    // Next partial remainder: shift in the next candidate bit, subtract
    // the divisor when it fits. The remainder stays below the divisor, so
    // one extra bit holds the shifted value.
    assign trial = {rem_reg, shift_reg[VALUE_WIDTH-1]};
    assign diff  = trial - {1'b0, div_reg};

    always_comb begin
        div_next   = div_reg;
        sq_next    = sq_reg;
        shift_next = shift_reg;
        rem_next   = rem_reg;
        cnt_next   = cnt_reg;
        if (cmd.load) begin
            div_next = DIV_W'(2);
            sq_next  = SQ_W'(4);
        end
        if (cmd.next_div) begin
            // (d + 1)^2 = d^2 + 2d + 1
            div_next = div_reg + DIV_W'(1);
            sq_next  = sq_reg + SQ_W'({div_reg, 1'b1});
        end
        if (cmd.div_start) begin
            shift_next = value_reg;
            rem_next   = '0;
            cnt_next   = CNT_W'(VALUE_WIDTH - 1);
        end
        if (cmd.div_step) begin
            shift_next = {shift_reg[VALUE_WIDTH-2:0], 1'b0};
            rem_next   = (trial >= {1'b0, div_reg}) ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
            cnt_next   = cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            value_reg <= in_value;
        end
        div_reg   <= div_next;
        sq_reg    <= sq_next;
        shift_reg <= shift_next;
        rem_reg   <= rem_next;
        cnt_reg   <= cnt_next;
        if (cmd.out_load) begin
            out_value_reg <= value_reg;
            out_prime_reg <= cmd.prime;
        end
    end

    assign status.le_one   = value_reg[VALUE_WIDTH-1] || (value_reg <= VALUE_WIDTH'(1));
    assign status.sq_over  = sq_reg > SQ_W'(value_reg);
    assign status.div_last = (cnt_reg == '0);
    assign status.rem_zero = (rem_reg == '0);

    assign out_value = out_value_reg;
    assign out_prime = out_prime_reg;

endmodule

### rtl/core/trial_division_prime_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trial_division_prime_test
// Tests a signed integer for primality by trial division and returns the
// integer with a prime flag.
// ----------------------------------------------------------------------------
//  Channel | Direction | tdata                       | tuser
//  s_      | in        | candidate                   | -
//  m_      | out       | tested_value                | is_prime
//
//  Each divisor passes one bound check, a remainder computation in the
//  one-bit-per-cycle remainder unit over all VALUE_WIDTH candidate bits
//  and one remainder test.
//  Reset is synchronous and active low; no clearing pass is needed.
//  A new item is taken once the previous search ends, even while the
//  previous result still waits in the output register.
// ----------------------------------------------------------------------------
module trial_division_prime_test #(
    parameter int VALUE_WIDTH = tdpt_pkg::VALUE_WIDTH_DEFAULT
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [((VALUE_WIDTH + 7) / 8)*8-1:0] s_tdata,  // candidate
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [((VALUE_WIDTH + 7) / 8)*8-1:0] m_tdata,  // tested_value
    output logic                                 m_tuser   // is_prime
);

    localparam int DATA_W = ((VALUE_WIDTH + 7) / 8) * 8;

    tdpt_pkg::dp_cmd_t      cmd;
    tdpt_pkg::dp_status_t   status;
    logic [VALUE_WIDTH-1:0] out_value;

    tdpt_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    tdpt_datapath #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_datapath (
        .aclk      (aclk),
        .in_value  (s_tdata[VALUE_WIDTH-1:0]),
        .cmd       (cmd),
        .status    (status),
        .out_value (out_value),
        .out_prime (m_tuser)
    );

    assign m_tdata = DATA_W'(out_value);

endmodule
